// ===== rtl/mfb_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mfb_pkg
// Shared codes and controller/datapath interface types for the monochrome
// framebuffer draw and refresh block.
// ---------------------------------------------------------------------------
package mfb_pkg;

  // request type codes
  localparam logic [2:0] REQ_SET_PIXEL   = 3'd0;
  localparam logic [2:0] REQ_CLEAR_PIXEL = 3'd1;
  localparam logic [2:0] REQ_HLINE       = 3'd2;
  localparam logic [2:0] REQ_VLINE       = 3'd3;
  localparam logic [2:0] REQ_CLEAR_ALL   = 3'd4;
  localparam logic [2:0] REQ_REFRESH     = 3'd5;

  // panel command bytes sent ahead of chunk zero
  localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
  localparam logic [7:0] CMD_COL_LOW   = 8'h00;
  localparam logic [7:0] CMD_COL_HIGH  = 8'h10;

  // index of each command byte in the preamble
  localparam logic [1:0] CMD_IDX_PAGE = 2'd0;
  localparam logic [1:0] CMD_IDX_LOW  = 2'd1;
  localparam logic [1:0] CMD_IDX_HIGH = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic load;      // latch the request fields, reset counters
    logic clr_step;  // write zero at sweep address, advance
    logic pix_rd;    // read byte under current run point
    logic pix_wr;    // write modified byte, advance run point
    logic cmd_emit;  // emit next preamble command byte
    logic dat_rd;    // read next column byte of the chunk
    logic dat_emit;  // emit column byte, advance column
  } mfb_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [2:0] req_type;
    logic       page_ok;
    logic       chunk_zero;
    logic       run_empty;
    logic       run_last;
    logic       clr_last;
    logic       cmd_last;
    logic       dat_last;
  } mfb_status_t;

endpackage

// ===== rtl/mfb_ctrl.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mfb_ctrl
// Sequencer for the framebuffer: clearing sweep, pixel read-modify-write
// runs and refresh byte emission.
// ---------------------------------------------------------------------------
module mfb_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  mfb_pkg::mfb_status_t status_i,
  output mfb_pkg::mfb_cmd_t    cmd_o,
  output logic                 busy_o
);
  import mfb_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_CLEAR  = 8'b0000_0010,
    ST_DECODE = 8'b0000_0100,
    ST_PIX_RD = 8'b0000_1000,
    ST_PIX_WR = 8'b0001_0000,
    ST_CMD    = 8'b0010_0000,
    ST_DAT_RD = 8'b0100_0000,
    ST_DAT_WR = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  // state register, reset enters the clearing sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and datapath commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DECODE;
        end
      end
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (status_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_DECODE: begin
        case (status_i.req_type)
          REQ_SET_PIXEL, REQ_CLEAR_PIXEL, REQ_HLINE, REQ_VLINE: begin
            state_d = status_i.run_empty ? ST_IDLE : ST_PIX_RD;
          end
          REQ_CLEAR_ALL: begin
            state_d = ST_CLEAR;
          end
          REQ_REFRESH: begin
            if (!status_i.page_ok) begin
              state_d = ST_IDLE;
            end else if (status_i.chunk_zero) begin
              state_d = ST_CMD;
            end else begin
              state_d = ST_DAT_RD;
            end
          end
          default: begin
            state_d = ST_IDLE;
          end
        endcase
      end
      ST_PIX_RD: begin
        cmd_o.pix_rd = 1'b1;
        state_d      = ST_PIX_WR;
      end
      ST_PIX_WR: begin
        cmd_o.pix_wr = 1'b1;
        state_d      = status_i.run_last ? ST_IDLE : ST_PIX_RD;
      end
      ST_CMD: begin
        cmd_o.cmd_emit = 1'b1;
        if (status_i.cmd_last) begin
          state_d = ST_DAT_RD;
        end
      end
      ST_DAT_RD: begin
        cmd_o.dat_rd = 1'b1;
        state_d      = ST_DAT_WR;
      end
      ST_DAT_WR: begin
        cmd_o.dat_emit = 1'b1;
        state_d        = status_i.dat_last ? ST_IDLE : ST_DAT_RD;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

// ===== rtl/mfb_datapath.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mfb_datapath
// Frame store memory, request registers, run and column counters and the
// registered result outputs.
// ---------------------------------------------------------------------------
module mfb_datapath #(
  parameter int COLUMNS       = 128,
  parameter int PAGES         = 8,
  parameter int CHUNK_COLUMNS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mfb_pkg::mfb_cmd_t    cmd_i,
  output mfb_pkg::mfb_status_t status_o,
  input  logic [2:0]           req_type_i,
  input  logic [7:0]           x_i,
  input  logic [7:0]           y_i,
  input  logic [7:0]           end_pos_i,
  input  logic [2:0]           page_i,
  input  logic [1:0]           chunk_i,
  output logic                 valid_o,
  output logic [7:0]           out_byte_o,
  output logic                 is_command_o,
  output logic                 last_o
);
  import mfb_pkg::*;

  localparam int DEPTH  = PAGES * COLUMNS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int PG_W   = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int CI_W   = (CHUNK_COLUMNS > 1) ? $clog2(CHUNK_COLUMNS) : 1;
  localparam int ROWS   = 8 * PAGES;

  // request registers
  logic [2:0] req_q;
  logic [7:0] x_q, y_q, pos_q;
  logic [8:0] end_q;
  logic [2:0] page_q;
  logic [1:0] chunk_q;

  // counters
  logic [ADDR_W-1:0] clr_cnt_q;
  logic [1:0]        cmd_cnt_q;
  logic [CI_W-1:0]   dat_cnt_q;
  logic              col_ok_q;

  // memory port
  logic [7:0]        mem [DEPTH];
  logic [7:0]        rdata_q;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [7:0]        mem_wdata;

  // output registers
  logic       valid_q;
  logic [7:0] out_byte_q;
  logic       is_command_q, last_q;

  // pixel addressing for the current run point
  logic [7:0]        pix_col, pix_row;
  logic              pix_in;
  logic [4:0]        row_pg_ext;
  logic [PG_W-1:0]   pix_pg;
  logic [ADDR_W-1:0] pix_addr;
  logic [7:0]        pix_mask;
  logic [7:0]        pix_new;
  logic [8:0]        col_ext;

  assign pix_col    = (req_q == REQ_VLINE) ? x_q : pos_q;
  assign pix_row    = (req_q == REQ_VLINE) ? pos_q : y_q;
  assign pix_in     = ({1'b0, pix_col} < 9'(COLUMNS)) && ({1'b0, pix_row} < 9'(ROWS));
  assign row_pg_ext = 5'(pix_row >> 3);
  assign pix_pg     = row_pg_ext[PG_W-1:0];
  assign col_ext    = {1'b0, pix_col};
  assign pix_addr   = ADDR_W'(pix_pg * COLUMNS) + ADDR_W'(col_ext[COL_W-1:0]);
  assign pix_mask   = 8'b1 << pix_row[2:0];
  assign pix_new    = (req_q == REQ_CLEAR_PIXEL) ? (rdata_q & ~pix_mask)
                                                 : (rdata_q | pix_mask);

  // refresh column addressing
  logic [4:0]        page_ext;
  logic [PG_W-1:0]   ref_pg;
  logic [8:0]        ref_col;
  logic              ref_col_ok;
  logic [ADDR_W-1:0] ref_addr;

  assign page_ext   = 5'(page_q);
  assign ref_pg     = page_ext[PG_W-1:0];
  assign ref_col    = 9'(chunk_q) * 9'(CHUNK_COLUMNS) + 9'(dat_cnt_q);
  assign ref_col_ok = ref_col < 9'(COLUMNS);
  assign ref_addr   = ADDR_W'(ref_pg * COLUMNS) + ADDR_W'(ref_col[COL_W-1:0]);

  // status back to the controller
  assign status_o.req_type   = req_q;
  assign status_o.page_ok    = page_ext < 5'(PAGES);
  assign status_o.chunk_zero = (chunk_q == 2'd0);
  assign status_o.run_empty  = ({1'b0, pos_q} >= end_q);
  assign status_o.run_last   = ({1'b0, pos_q} + 9'd1 >= end_q);
  assign status_o.clr_last   = (clr_cnt_q == ADDR_W'(DEPTH - 1));
  assign status_o.cmd_last   = (cmd_cnt_q == CMD_IDX_HIGH);
  assign status_o.dat_last   = (dat_cnt_q == CI_W'(CHUNK_COLUMNS - 1));

  // request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q   <= req_type_i;
      x_q     <= x_i;
      y_q     <= y_i;
      page_q  <= page_i;
      chunk_q <= chunk_i;
      if (req_type_i == REQ_VLINE) begin
        end_q <= {1'b0, end_pos_i};
      end else if (req_type_i == REQ_HLINE) begin
        end_q <= {1'b0, end_pos_i};
      end else begin
        end_q <= {1'b0, x_i} + 9'd1;
      end
    end
  end

  // run position
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pos_q <= (req_type_i == REQ_VLINE) ? y_i : x_i;
    end else if (cmd_i.pix_wr) begin
      pos_q <= pos_q + 8'd1;
    end
  end

  // sweep, preamble and column counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
      cmd_cnt_q <= CMD_IDX_PAGE;
      dat_cnt_q <= '0;
      col_ok_q  <= 1'b0;
    end else begin
      if (cmd_i.clr_step) begin
        clr_cnt_q <= status_o.clr_last ? '0 : clr_cnt_q + 1'b1;
      end
      if (cmd_i.load) begin
        cmd_cnt_q <= CMD_IDX_PAGE;
        dat_cnt_q <= '0;
      end else begin
        if (cmd_i.cmd_emit) begin
          cmd_cnt_q <= cmd_cnt_q + 2'd1;
        end
        if (cmd_i.dat_emit) begin
          dat_cnt_q <= dat_cnt_q + 1'b1;
        end
      end
      if (cmd_i.dat_rd) begin
        col_ok_q <= ref_col_ok;
      end
    end
  end

  // memory port selection
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_cnt_q;
    mem_wdata = 8'h00;
    mem_re    = 1'b0;
    mem_raddr = pix_addr;
    if (cmd_i.clr_step) begin
      mem_we = 1'b1;
    end else if (cmd_i.pix_wr && pix_in) begin
      mem_we    = 1'b1;
      mem_waddr = pix_addr;
      mem_wdata = pix_new;
    end
    if (cmd_i.pix_rd && pix_in) begin
      mem_re = 1'b1;
    end else if (cmd_i.dat_rd && ref_col_ok) begin
      mem_re    = 1'b1;
      mem_raddr = ref_addr;
    end
  end

  // frame store
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  // result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.cmd_emit | cmd_i.dat_emit;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.cmd_emit) begin
      is_command_q <= 1'b1;
      last_q       <= 1'b0;
      case (cmd_cnt_q)
        CMD_IDX_PAGE: out_byte_q <= CMD_PAGE_BASE + {5'd0, page_q};
        CMD_IDX_LOW:  out_byte_q <= CMD_COL_LOW;
        CMD_IDX_HIGH: out_byte_q <= CMD_COL_HIGH;
        default:      out_byte_q <= CMD_COL_LOW;
      endcase
    end else if (cmd_i.dat_emit) begin
      is_command_q <= 1'b0;
      last_q       <= status_o.dat_last;
      out_byte_q   <= col_ok_q ? rdata_q : 8'h00;
    end
  end

  assign valid_o      = valid_q;
  assign out_byte_o   = out_byte_q;
  assign is_command_o = is_command_q;
  assign last_o       = last_q;

endmodule

// ===== rtl/mono_framebuffer_draw_refresh.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mono_framebuffer_draw_refresh
// Page-addressed one-bit framebuffer with pixel, run, clear and refresh
// requests; a refresh produces panel command and data bytes.
// ---------------------------------------------------------------------------
// A request is taken when start_i is high while busy_o is low. Results come
// out one byte per valid_o pulse, each present for a single cycle, and the
// receiver cannot stall them. After reset the block is busy while it sweeps
// zeros into every frame store address; a clear-all request repeats that
// sweep. The frame store has a single read and a single write port, so each
// run point costs a read and then a write, and set and clear pixel are runs
// of one point. A refresh reads and emits one column byte after another for
// the chunk, after the three-byte command preamble on chunk zero. Requests
// with no results still pass through the decode state and hold busy_o there.
module mono_framebuffer_draw_refresh #(
  parameter int COLUMNS       = 128,
  parameter int PAGES         = 8,
  parameter int CHUNK_COLUMNS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  input  logic [2:0] req_type_i,
  input  logic [7:0] x_i,
  input  logic [7:0] y_i,
  input  logic [7:0] end_pos_i,
  input  logic [2:0] page_i,
  input  logic [1:0] chunk_i,
  output logic       valid_o,
  output logic [7:0] out_byte_o,
  output logic       is_command_o,
  output logic       last_o
);
  import mfb_pkg::*;

  mfb_cmd_t    cmd;
  mfb_status_t status;

  // sequencer
  mfb_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  // store and result datapath
  mfb_datapath #(
    .COLUMNS       (COLUMNS),
    .PAGES         (PAGES),
    .CHUNK_COLUMNS (CHUNK_COLUMNS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .req_type_i   (req_type_i),
    .x_i          (x_i),
    .y_i          (y_i),
    .end_pos_i    (end_pos_i),
    .page_i       (page_i),
    .chunk_i      (chunk_i),
    .valid_o      (valid_o),
    .out_byte_o   (out_byte_o),
    .is_command_o (is_command_o),
    .last_o       (last_o)
  );

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for mono_framebuffer_draw_refresh. A shadow copy of the
// frame store is updated on every accepted request, and refresh chunks are
// turned into the panel bytes they must produce. The monitor checks each
// byte strobe against the oldest pending byte. Directed corner cases are
// followed by random drawing and refresh traffic.
// ---------------------------------------------------------------------------
module testbench;
  import mfb_pkg::*;

  localparam int COLS       = 128;
  localparam int PGS        = 8;
  localparam int CHUNK_COLS = 32;

  // request codes that the block treats as no-ops
  localparam logic [2:0] REQ_SPARE_6 = 3'd6;
  localparam logic [2:0] REQ_SPARE_7 = 3'd7;

  localparam int unsigned TOTAL_ITEMS = 420;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned TAIL_CYCLES = 1100;
  localparam int unsigned CYCLE_LIMIT = 3000000;

  typedef struct {
    logic [2:0] kind;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] end_pos;
    logic [2:0] page;
    logic [1:0] chunk;
    bit         hold;  // wait for all pending bytes before launching
  } draw_req_t;

  typedef struct {
    logic [7:0] data;
    logic       is_cmd;
    logic       last;
  } panel_byte_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start_i = 1'b0;
  logic       busy_o;
  logic [2:0] req_type_i = '0;
  logic [7:0] x_i = '0;
  logic [7:0] y_i = '0;
  logic [7:0] end_pos_i = '0;
  logic [2:0] page_i = '0;
  logic [1:0] chunk_i = '0;
  logic       valid_o;
  logic [7:0] out_byte_o;
  logic       is_command_o;
  logic       last_o;

  draw_req_t   pending_reqs[$];
  draw_req_t   on_bus;
  panel_byte_t panel_bytes_due[$];
  logic [7:0]  shadow_store[PGS*COLS];

  int unsigned queued_total = 0;
  int unsigned launched = 0;
  int unsigned requests_taken = 0;
  int unsigned refreshes_taken = 0;
  int unsigned sweeps_taken = 0;
  int unsigned bytes_checked = 0;
  int unsigned errors = 0;
  int unsigned cycle_count = 0;

  mono_framebuffer_draw_refresh #(
    .COLUMNS      (COLS),
    .PAGES        (PGS),
    .CHUNK_COLUMNS(CHUNK_COLS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .req_type_i  (req_type_i),
    .x_i         (x_i),
    .y_i         (y_i),
    .end_pos_i   (end_pos_i),
    .page_i      (page_i),
    .chunk_i     (chunk_i),
    .valid_o     (valid_o),
    .out_byte_o  (out_byte_o),
    .is_command_o(is_command_o),
    .last_o      (last_o)
  );

  // clock, 8 ns period
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  // ---------------- shadow frame store ----------------

  task automatic flag_error(input string msg);
    if (errors < MAX_REPORTS) $display("[%0t] ERROR: %s", $time, msg);
    errors++;
  endtask

  task automatic plot(input int unsigned col, input int unsigned row, input bit on);
    int unsigned idx;
    // points off the panel are dropped
    if (col < COLS && row < 8 * PGS) begin
      idx = (row >> 3) * COLS + col;
      shadow_store[idx][row & 7] = on;
    end
  endtask

  task automatic due_byte(input logic [7:0] data, input logic is_cmd, input logic last);
    panel_byte_t b;
    b.data   = data;
    b.is_cmd = is_cmd;
    b.last   = last;
    panel_bytes_due.push_back(b);
  endtask

  // update the shadow store and queue the bytes a request must produce
  task automatic apply_request(input draw_req_t r);
    int unsigned pos;
    int unsigned col;
    logic [7:0]  col_byte;
    case (r.kind)
      REQ_SET_PIXEL:   plot(r.x, r.y, 1'b1);
      REQ_CLEAR_PIXEL: plot(r.x, r.y, 1'b0);
      REQ_HLINE: begin
        for (pos = r.x; pos < r.end_pos; pos++) plot(pos, r.y, 1'b1);
      end
      REQ_VLINE: begin
        for (pos = r.y; pos < r.end_pos; pos++) plot(r.x, pos, 1'b1);
      end
      REQ_CLEAR_ALL: begin
        foreach (shadow_store[i]) shadow_store[i] = '0;
        sweeps_taken++;
      end
      REQ_REFRESH: begin
        if (r.page < PGS) begin
          // page/column address preamble only on the first chunk
          if (r.chunk == 2'd0) begin
            due_byte(CMD_PAGE_BASE + {5'd0, r.page}, 1'b1, 1'b0);
            due_byte(CMD_COL_LOW, 1'b1, 1'b0);
            due_byte(CMD_COL_HIGH, 1'b1, 1'b0);
          end
          for (pos = 0; pos < CHUNK_COLS; pos++) begin
            col = r.chunk * CHUNK_COLS + pos;
            col_byte = (col < COLS) ? shadow_store[r.page * COLS + col] : 8'h00;
            due_byte(col_byte, 1'b0, pos == CHUNK_COLS - 1);
          end
          refreshes_taken++;
        end
      end
      default: ;  // spare codes do nothing
    endcase
  endtask

  // ---------------- stimulus ----------------

  task automatic add_req(input logic [2:0] kind, input logic [7:0] x, input logic [7:0] y,
                         input logic [7:0] end_pos, input logic [2:0] page,
                         input logic [1:0] chunk, input bit hold);
    draw_req_t r;
    r.kind    = kind;
    r.x       = x;
    r.y       = y;
    r.end_pos = end_pos;
    r.page    = page;
    r.chunk   = chunk;
    r.hold    = hold;
    pending_reqs.push_back(r);
    queued_total++;
  endtask

  // mostly on-panel coordinates, sometimes anything the field holds
  function automatic logic [7:0] rand_col();
    return ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, COLS - 1))
                                        : 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] rand_row();
    return ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, 8 * PGS - 1))
                                        : 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] run_end(input logic [7:0] start, input int unsigned span);
    int unsigned e;
    if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
    e = start + $urandom_range(0, span);
    return (e > 255) ? 8'd255 : 8'(e);
  endfunction

  task automatic add_directed();
    // corners and off-panel points
    add_req(REQ_SET_PIXEL, 8'd0, 8'd0, 8'd0, 3'd0, 2'd0, 1'b0);
    add_req(REQ_SET_PIXEL, 8'd127, 8'd63, 8'd0, 3'd0, 2'd0, 1'b0);
    add_req(REQ_SET_PIXEL, 8'd128, 8'd5, 8'd0, 3'd0, 2'd0, 1'b0);
    add_req(REQ_SET_PIXEL, 8'd5, 8'd64, 8'd0, 3'd0, 2'd0, 1'b0);
    add_req(REQ_SET_PIXEL, 8'd255, 8'd255, 8'd255, 3'd7, 2'd3, 1'b0);
    // full-width run that walks past the right edge
    add_req(REQ_HLINE, 8'd0, 8'd10, 8'd255, 3'd0, 2'd0, 1'b0);
    // empty runs: end equal to start, end below start
    add_req(REQ_HLINE, 8'd100, 8'd20, 8'd100, 3'd0, 2'd0, 1'b0);
    add_req(REQ_HLINE, 8'd200, 8'd3, 8'd150, 3'd0, 2'd0, 1'b0);
    // full-height run past the bottom, and a run in an off-panel column
    add_req(REQ_VLINE, 8'd64, 8'd0, 8'd255, 3'd0, 2'd0, 1'b0);
    add_req(REQ_VLINE, 8'd200, 8'd0, 8'd64, 3'd0, 2'd0, 1'b0);
    add_req(REQ_CLEAR_PIXEL, 8'd64, 8'd10, 8'd0, 3'd0, 2'd0, 1'b0);
    add_req(REQ_CLEAR_PIXEL, 8'd255, 8'd0, 8'd0, 3'd0, 2'd0, 1'b0);
    // spare request codes
    add_req(REQ_SPARE_6, 8'd1, 8'd1, 8'd9, 3'd1, 2'd0, 1'b0);
    add_req(REQ_SPARE_7, 8'd2, 8'd2, 8'd9, 3'd2, 2'd0, 1'b0);
    // refresh every chunk of page 0, then pages 1 and 7
    add_req(REQ_REFRESH, 8'd0, 8'd0, 8'd0, 3'd0, 2'd0, 1'b0);
    add_req(REQ_REFRESH, 8'd0, 8'd0, 8'd0, 3'd0, 2'd1, 1'b0);
    add_req(REQ_REFRESH, 8'd0, 8'd0, 8'd0, 3'd0, 2'd2, 1'b0);
    add_req(REQ_REFRESH, 8'd0, 8'd0, 8'd0, 3'd0, 2'd3, 1'b0);
    add_req(REQ_REFRESH, 8'd0, 8'd0, 8'd0, 3'd1, 2'd0, 1'b0);
    add_req(REQ_REFRESH, 8'd0, 8'd0, 8'd0, 3'd7, 2'd3, 1'b0);
    add_req(REQ_CLEAR_ALL, 8'd0, 8'd0, 8'd0, 3'd0, 2'd0, 1'b0);
    // sender waits for all pending panel bytes to drain before this one
    add_req(REQ_REFRESH, 8'd0, 8'd0, 8'd0, 3'd1, 2'd1, 1'b1);
    add_req(REQ_VLINE, 8'd127, 8'd63, 8'd64, 3'd0, 2'd0, 1'b0);
    add_req(REQ_REFRESH, 8'hff, 8'hff, 8'hff, 3'd7, 2'd3, 1'b0);
  endtask

  task automatic add_random();
    int unsigned pick;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [2:0]  pg;
    bit          hold;
    while (queued_total < TOTAL_ITEMS) begin
      pick = $urandom_range(0, 99);
      x    = rand_col();
      y    = rand_row();
      pg   = 3'($urandom_range(0, 7));
      hold = ($urandom_range(0, 99) < 3);
      if (pick < 20) begin
        add_req(REQ_SET_PIXEL, x, y, 8'($urandom), pg, 2'($urandom), hold);
      end else if (pick < 30) begin
        add_req(REQ_CLEAR_PIXEL, x, y, 8'($urandom), pg, 2'($urandom), hold);
      end else if (pick < 44) begin
        add_req(REQ_HLINE, x, y, run_end(x, 48), pg, 2'($urandom), hold);
      end else if (pick < 58) begin
        add_req(REQ_VLINE, x, y, run_end(y, 24), pg, 2'($urandom), hold);
      end else if (pick < 61) begin
        add_req(REQ_CLEAR_ALL, x, y, 8'($urandom), pg, 2'($urandom), hold);
      end else if (pick < 66) begin
        add_req(($urandom_range(0, 1) == 0) ? REQ_SPARE_6 : REQ_SPARE_7,
                x, y, 8'($urandom), pg, 2'($urandom), hold);
      end else if (pick < 78) begin
        add_req(REQ_REFRESH, x, y, 8'($urandom), pg, 2'($urandom), hold);
      end else begin
        // a whole page, chunk by chunk, as the panel driver would send it
        for (int c = 0; c < 4; c++)
          add_req(REQ_REFRESH, 8'($urandom), 8'($urandom), 8'($urandom), pg, 2'(c),
                  hold && c == 0);
      end
    end
  endtask

  function automatic int unsigned sender_idle_pct(input int unsigned n);
    if (n < TOTAL_ITEMS / 3) return 32;
    if (n < 2 * TOTAL_ITEMS / 3) return 72;
    return 0;
  endfunction

  // ---------------- driver ----------------

  // a request transfers when start_i is high and busy_o is low at the edge
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else begin
      if (start_i && !busy_o) begin
        apply_request(on_bus);
        requests_taken++;
      end
      if (!(start_i && busy_o)) begin
        if (pending_reqs.size() != 0 &&
            $urandom_range(0, 99) >= sender_idle_pct(launched) &&
            (!pending_reqs[0].hold || panel_bytes_due.size() == 0)) begin
          on_bus = pending_reqs.pop_front();
          req_type_i <= on_bus.kind;
          x_i        <= on_bus.x;
          y_i        <= on_bus.y;
          end_pos_i  <= on_bus.end_pos;
          page_i     <= on_bus.page;
          chunk_i    <= on_bus.chunk;
          start_i    <= 1'b1;
          launched++;
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // ---------------- monitor ----------------

  // each valid_o strobe is one byte transfer, checked against the oldest due byte
  always @(posedge clk_i) begin
    panel_byte_t want;
    if (rst_ni && valid_o) begin
      if (panel_bytes_due.size() == 0) begin
        flag_error($sformatf("unexpected byte %02h cmd=%0b last=%0b",
                             out_byte_o, is_command_o, last_o));
      end else begin
        want = panel_bytes_due.pop_front();
        if (out_byte_o !== want.data || is_command_o !== want.is_cmd ||
            last_o !== want.last)
          flag_error($sformatf("byte mismatch: want %02h cmd=%0b last=%0b, got %02h cmd=%0b last=%0b",
                               want.data, want.is_cmd, want.last,
                               out_byte_o, is_command_o, last_o));
        bytes_checked++;
      end
    end
  end

  // ---------------- run control ----------------

  initial begin
    foreach (shadow_store[i]) shadow_store[i] = '0;
    add_directed();
    add_random();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (requests_taken < queued_total) @(posedge clk_i);
    while (panel_bytes_due.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (panel_bytes_due.size() != 0)
      flag_error($sformatf("%0d bytes never arrived", panel_bytes_due.size()));
    $display("covered %0d requests: %0d refresh chunks, %0d clear-all sweeps",
             requests_taken, refreshes_taken, sweeps_taken);
    $display("checked %0d panel bytes, %0d errors", bytes_checked, errors);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk_i);
    $display("timeout after %0d cycles", cycle_count);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/mfb_pkg.sv
rtl/mfb_ctrl.sv
rtl/mfb_datapath.sv
rtl/mono_framebuffer_draw_refresh.sv
bench/testbench.sv
